// ===== design/sliding_window_statistics_macros.svh =====
// ----------------------------------------------------------------------------
// Sliding window statistics assertion macros
// Concurrent assertion forms used by the back end.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_STATISTICS_MACROS_SVH
`define SLIDING_WINDOW_STATISTICS_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SWS_ASSERT_IMPL(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("sliding window statistics assertion failed");

// Next-cycle implication, disabled during reset.
`define SWS_ASSERT_NEXT(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("sliding window statistics assertion failed");

`endif

// ===== design/swst_pkg.sv =====
// ----------------------------------------------------------------------------
// Sliding window statistics package
// Shared types and fixed constants for the statistics block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package swst_pkg;

  // Reset value of the window length register.
  localparam logic [7:0] WINDOW_LEN_RESET = 8'd100;

  // Register index carried in paddr[2].
  localparam logic REG_WINDOW_LEN = 1'b0;

  // Fraction bits of the mean and of the scaled variance.
  localparam int MEAN_FRAC = 8;
  localparam int VAR_FRAC  = 16;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVICT,
    ST_PUSH,
    ST_PROD,
    ST_DIFF,
    ST_MEAN_GO,
    ST_MEAN_WAIT,
    ST_VAR_GO,
    ST_VAR_WAIT,
    ST_ROOT_GO,
    ST_ROOT_WAIT,
    ST_FINISH
  } seq_state_t;

  // Status of a multi-cycle arithmetic unit.
  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

endpackage

// ===== design/swst_front.sv =====
// ----------------------------------------------------------------------------
// Sliding window statistics front end
// Accepts samples, keeps their low SAMPLE_BITS bits and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swst_front #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sample_valid,
  output logic                          sample_stall,
  input  logic [23:0]                   sample,
  input  logic                          q_pop,
  output logic                          q_valid,
  output logic signed [SAMPLE_BITS-1:0] q_sample
);

  logic signed [SAMPLE_BITS-1:0] slot [2];
  logic                          wptr;
  logic                          rptr;
  logic [1:0]                    count;
  logic                          push;
  logic                          pop;

  assign sample_stall = (count == 2'd2);
  assign q_valid      = (count != 2'd0);
  assign q_sample     = slot[rptr];
  assign push         = sample_valid && !sample_stall;
  assign pop          = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  // Only the low SAMPLE_BITS bits carry the sample.
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wptr] <= sample[SAMPLE_BITS-1:0];
    end
  end

endmodule

// ===== design/swst_div.sv =====
// ----------------------------------------------------------------------------
// Sliding window statistics divider
// Unsigned restoring divider retiring two quotient bits per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swst_div #(
  parameter int DVD_W = 80,
  parameter int DVS_W = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [DVD_W-1:0]        dividend,
  input  logic [DVS_W-1:0]        divisor,
  output logic [DVD_W-1:0]        quotient,
  output logic [DVS_W-1:0]        remainder,
  output swst_pkg::unit_status_t  status
);

  localparam int STEPS = DVD_W / 2;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [DVD_W-1:0] work;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [DVS_W:0]   s1;
  logic [DVS_W:0]   s2;

  function automatic logic [DVS_W:0] div_step(input logic [DVS_W-1:0] r, input logic b,
                                               input logic [DVS_W-1:0] d);
    logic [DVS_W:0] t;
    logic [DVS_W:0] dd;
    t  = {r, b};
    dd = {1'b0, d};
    if (t >= dd) begin
      return {1'b1, DVS_W'(t - dd)};
    end
    return {1'b0, t[DVS_W-1:0]};
  endfunction

  assign s1 = div_step(rem, work[DVD_W-1], dvs);
  assign s2 = div_step(s1[DVS_W-1:0], work[DVD_W-2], dvs);

  assign quotient    = work;
  assign remainder   = rem;
  assign status.busy = busy;
  assign status.done = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(STEPS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      work <= {work[DVD_W-3:0], s1[DVS_W], s2[DVS_W]};
      rem  <= s2[DVS_W-1:0];
    end
  end

endmodule

// ===== design/swst_isqrt.sv =====
// ----------------------------------------------------------------------------
// Sliding window statistics square root
// Digit-by-digit integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swst_isqrt #(
  parameter int RAD_W = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [RAD_W-1:0]       radicand,
  output logic [RAD_W/2-1:0]     root,
  output swst_pkg::unit_status_t status
);

  localparam int H     = RAD_W / 2;
  localparam int CNT_W = $clog2(H + 1);

  logic [RAD_W-1:0] x;
  logic [H:0]       rem;
  logic [H-1:0]     res;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [H+2:0]     pre;
  logic [H+2:0]     trial;
  logic             fits;

  assign pre   = {rem, x[RAD_W-1 -: 2]};
  assign trial = (H + 3)'({res, 2'b01});
  assign fits  = (pre >= trial);

  assign root        = res;
  assign status.busy = busy;
  assign status.done = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(H);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x   <= radicand;
      rem <= '0;
      res <= '0;
    end else if (busy) begin
      x <= {x[RAD_W-3:0], 2'b00};
      if (fits) begin
        rem <= (H + 1)'(pre - trial);
        res <= {res[H-2:0], 1'b1};
      end else begin
        rem <= pre[H:0];
        res <= {res[H-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== design/swst_back.sv =====
// ----------------------------------------------------------------------------
// Sliding window statistics back end
// Keeps the sample ring and running sums and sequences the arithmetic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sliding_window_statistics_macros.svh"

module swst_back #(
  parameter int WINDOW_MAX  = 128,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                clear,
  input  logic [$clog2(WINDOW_MAX+1)-1:0]     eff_len,
  input  logic                                q_valid,
  input  logic signed [SAMPLE_BITS-1:0]       q_sample,
  output logic                                q_pop,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic [7:0]                          fill_count,
  output logic signed [23:0]                  window_min,
  output logic signed [23:0]                  window_max,
  output logic signed [31:0]                  mean_q8,
  output logic [31:0]                         stddev_q8
);

  localparam int S       = SAMPLE_BITS;
  localparam int PTR_W   = $clog2(WINDOW_MAX);
  localparam int CNT_W   = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W   = S + PTR_W + 1;
  localparam int SQ_W    = 2 * S + PTR_W;
  localparam int D_W     = SQ_W + CNT_W;
  localparam int DVS_W   = 2 * CNT_W;
  localparam int VAR_W   = 2 * S + swst_pkg::VAR_FRAC;
  localparam int DVD_RAW = D_W + swst_pkg::VAR_FRAC;
  localparam int DVD_W   = ((DVD_RAW + 1) / 2) * 2;

  swst_pkg::seq_state_t state, state_next;

  logic signed [S-1:0]     ring [WINDOW_MAX];
  logic signed [S-1:0]     rd_data;
  logic [PTR_W-1:0]        rd_addr;
  logic [PTR_W-1:0]        wr_addr;
  logic                    wr_en;

  logic [PTR_W-1:0]        oldest;
  logic [CNT_W-1:0]        held;
  logic signed [SUM_W-1:0] sum;
  logic [SQ_W-1:0]         sq;
  logic signed [S-1:0]     x;
  logic                    full;

  logic signed [2*S-1:0]   rd_w;
  logic signed [2*S-1:0]   x_w;
  logic [2*S-1:0]          old_sq;
  logic [2*S-1:0]          x_sq;
  logic signed [2*SUM_W-1:0] sum_w;

  logic [D_W-1:0]          nsq;
  logic [2*SUM_W-1:0]      ss;
  logic [DVS_W-1:0]        den;
  logic [D_W-1:0]          dvar;
  logic [SUM_W-1:0]        mag;
  logic                    neg;
  logic signed [S-1:0]     mn;
  logic signed [S-1:0]     mx;
  logic [31:0]             mean;
  logic [31:0]             q32;
  logic [VAR_W-1:0]        var_q;
  logic [31:0]             stddev;

  logic                    scan_active;
  logic                    scan_vld;
  logic [CNT_W-1:0]        scan_idx;
  logic                    scan_done;

  logic                    div_start;
  logic [DVD_W-1:0]        div_dvd;
  logic [DVS_W-1:0]        div_dvs;
  logic [DVD_W-1:0]        div_q;
  logic [DVS_W-1:0]        div_r;
  swst_pkg::unit_status_t  div_st;

  logic                    sqrt_start;
  logic [VAR_W/2-1:0]      sqrt_root;
  swst_pkg::unit_status_t  sqrt_st;

  logic                    load;

  function automatic logic [PTR_W-1:0] wrap(input logic [CNT_W:0] a);
    logic [CNT_W:0] lim;
    lim = (CNT_W + 1)'(WINDOW_MAX);
    if (a >= lim) begin
      return PTR_W'(a - lim);
    end
    return PTR_W'(a);
  endfunction

  assign full      = (held >= eff_len);
  assign scan_done = !scan_active && !scan_vld;
  assign rd_w      = (2 * S)'(rd_data);
  assign x_w       = (2 * S)'(x);
  assign old_sq    = rd_w * rd_w;
  assign x_sq      = x_w * x_w;
  assign sum_w     = (2 * SUM_W)'(sum);
  assign q32       = div_q[31:0];

  assign rd_addr = scan_active ? wrap((CNT_W + 1)'(oldest) + (CNT_W + 1)'(scan_idx)) : oldest;
  assign wr_addr = wrap((CNT_W + 1)'(oldest) + (CNT_W + 1)'(held));

  assign div_dvd = (state == swst_pkg::ST_VAR_GO)
                 ? DVD_W'({dvar, {swst_pkg::VAR_FRAC{1'b0}}})
                 : DVD_W'({mag, {swst_pkg::MEAN_FRAC{1'b0}}});
  assign div_dvs = (state == swst_pkg::ST_VAR_GO) ? den : DVS_W'(held);

  swst_div #(
    .DVD_W (DVD_W),
    .DVS_W (DVS_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .quotient  (div_q),
    .remainder (div_r),
    .status    (div_st)
  );

  swst_isqrt #(
    .RAD_W (VAR_W)
  ) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (var_q),
    .root     (sqrt_root),
    .status   (sqrt_st)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swst_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    wr_en      = 1'b0;
    div_start  = 1'b0;
    sqrt_start = 1'b0;
    load       = 1'b0;
    case (state)
      swst_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = swst_pkg::ST_EVICT;
        end
      end
      swst_pkg::ST_EVICT: state_next = swst_pkg::ST_PUSH;
      swst_pkg::ST_PUSH: begin
        wr_en      = 1'b1;
        state_next = swst_pkg::ST_PROD;
      end
      swst_pkg::ST_PROD:    state_next = swst_pkg::ST_DIFF;
      swst_pkg::ST_DIFF:    state_next = swst_pkg::ST_MEAN_GO;
      swst_pkg::ST_MEAN_GO: begin
        div_start  = 1'b1;
        state_next = swst_pkg::ST_MEAN_WAIT;
      end
      swst_pkg::ST_MEAN_WAIT: begin
        if (div_st.done) begin
          state_next = (held > CNT_W'(1)) ? swst_pkg::ST_VAR_GO : swst_pkg::ST_FINISH;
        end
      end
      swst_pkg::ST_VAR_GO: begin
        div_start  = 1'b1;
        state_next = swst_pkg::ST_VAR_WAIT;
      end
      swst_pkg::ST_VAR_WAIT: begin
        if (div_st.done) begin
          state_next = swst_pkg::ST_ROOT_GO;
        end
      end
      swst_pkg::ST_ROOT_GO: begin
        sqrt_start = 1'b1;
        state_next = swst_pkg::ST_ROOT_WAIT;
      end
      swst_pkg::ST_ROOT_WAIT: begin
        if (sqrt_st.done) begin
          state_next = swst_pkg::ST_FINISH;
        end
      end
      swst_pkg::ST_FINISH: begin
        if (scan_done && (!result_valid || !result_stall)) begin
          load       = 1'b1;
          state_next = swst_pkg::ST_IDLE;
        end
      end
      default: state_next = swst_pkg::ST_IDLE;
    endcase
  end

  // Window state: ring pointers and running sums.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      oldest <= '0;
      held   <= '0;
      sum    <= '0;
      sq     <= '0;
    end else begin
      case (state)
        swst_pkg::ST_EVICT: begin
          if (full) begin
            sum    <= sum - SUM_W'(rd_data);
            sq     <= sq - SQ_W'(old_sq);
            oldest <= wrap((CNT_W + 1)'(oldest) + (CNT_W + 1)'(1));
            held   <= held - 1'b1;
          end
        end
        swst_pkg::ST_PUSH: begin
          sum  <= sum + SUM_W'(x);
          sq   <= sq + SQ_W'(x_sq);
          held <= held + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // The min/max scan walks the window while the divider works.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_active <= 1'b0;
      scan_vld    <= 1'b0;
      scan_idx    <= '0;
    end else begin
      scan_vld <= scan_active;
      if (state == swst_pkg::ST_PROD) begin
        scan_active <= 1'b1;
        scan_idx    <= '0;
      end else if (scan_active) begin
        scan_idx <= scan_idx + 1'b1;
        if (scan_idx == held - 1'b1) begin
          scan_active <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring[wr_addr] <= x;
    end
    rd_data <= ring[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      x <= q_sample;
    end
    if (state == swst_pkg::ST_PUSH) begin
      mn <= x;
      mx <= x;
    end else if (scan_vld) begin
      if (rd_data < mn) begin
        mn <= rd_data;
      end
      if (rd_data > mx) begin
        mx <= rd_data;
      end
    end
    if (state == swst_pkg::ST_PROD) begin
      nsq <= held * sq;
      ss  <= sum_w * sum_w;
      den <= held * (held - 1'b1);
    end
    if (state == swst_pkg::ST_DIFF) begin
      dvar <= (nsq >= D_W'(ss)) ? nsq - D_W'(ss) : '0;
      mag  <= (sum < 0) ? SUM_W'(-sum) : SUM_W'(sum);
      neg  <= (sum < 0);
      stddev <= '0;
    end
    if (state == swst_pkg::ST_MEAN_WAIT && div_st.done) begin
      mean <= neg ? -(q32 + 32'(div_r != '0)) : q32;
    end
    if (state == swst_pkg::ST_VAR_WAIT && div_st.done) begin
      var_q <= div_q[VAR_W-1:0];
    end
    if (state == swst_pkg::ST_ROOT_WAIT && sqrt_st.done) begin
      stddev <= 32'(sqrt_root);
    end
    if (load) begin
      fill_count <= 8'(held);
      window_min <= 24'(mn);
      window_max <= 24'(mx);
      mean_q8    <= mean;
      stddev_q8  <= stddev;
    end
  end

  `SWS_ASSERT_IMPL(a_held_in_window, clk, rst, state == swst_pkg::ST_IDLE, held <= eff_len)
  `SWS_ASSERT_IMPL(a_div_start_idle, clk, rst, div_start, !div_st.busy)
  `SWS_ASSERT_IMPL(a_root_needs_two, clk, rst, sqrt_start, held > CNT_W'(1))
  `SWS_ASSERT_NEXT(a_push_fills, clk, rst, state == swst_pkg::ST_PUSH, held != '0)

endmodule

// ===== design/sliding_window_statistics.sv =====
// ----------------------------------------------------------------------------
// Sliding window statistics
// Samples arrive on the sample channel (sample_valid / sample_stall); a request
// is taken at a rising edge with valid high and stall low. Each sample yields one
// result request: fill count, window minimum and maximum, and the mean and sample
// standard deviation with 8 fraction bits, floored. A two-entry queue in front
// takes the next sample while the current one is still being worked on.
// After a sample is taken, the back end updates the ring, the sums and the
// products, runs the radix-4 mean divide, the variance divide and the square
// root, and then loads the result. A single sample skips the variance divide and
// the square root. The min/max scan reads one ring entry per held sample
// alongside the divides; with the default parameters it is the longer path above
// 118 held samples. The back end takes the next queued sample in the cycle after
// a result loads, so it does not start a sample before the last result is loaded.
// Reset, and any write of window_len over the APB port, empties the window.
// A stalled result stays in the output register; the next finished result waits
// until it is taken, and the queue then fills and stalls the sender.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sliding_window_statistics #(
  parameter int WINDOW_MAX  = 128,
  parameter int SAMPLE_BITS = 24
) (
  input  logic               clk,
  input  logic               rst,
  // Configuration port.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // Sample channel.
  input  logic               sample_valid,
  output logic               sample_stall,
  input  logic signed [23:0] sample,
  // Result channel.
  output logic               result_valid,
  input  logic               result_stall,
  output logic [7:0]         fill_count,
  output logic signed [23:0] window_min,
  output logic signed [23:0] window_max,
  output logic signed [31:0] mean_q8,
  output logic [31:0]        stddev_q8
);

  localparam int CNT_W = $clog2(WINDOW_MAX + 1);

  logic [7:0]                    window_len;
  logic                          cfg_write;
  logic                          clear;
  logic [15:0]                   len_wide;
  logic [CNT_W-1:0]              eff_len;
  logic                          q_valid;
  logic                          q_pop;
  logic signed [SAMPLE_BITS-1:0] q_sample;

  // The only register sits at byte address 0; paddr[2] selects the index.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign clear     = cfg_write && (paddr[2] == swst_pkg::REG_WINDOW_LEN);
  assign prdata    = (paddr[2] == swst_pkg::REG_WINDOW_LEN) ? 32'(window_len) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= swst_pkg::WINDOW_LEN_RESET;
    end else if (clear) begin
      window_len <= pwdata[7:0];
    end
  end

  // A length of zero behaves as one, and anything above the ring depth is
  // limited to the ring depth.
  assign len_wide = 16'(window_len);
  always_comb begin
    if (len_wide == '0) begin
      eff_len = CNT_W'(1);
    end else if (len_wide > 16'(WINDOW_MAX)) begin
      eff_len = CNT_W'(WINDOW_MAX);
    end else begin
      eff_len = CNT_W'(len_wide);
    end
  end

  swst_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .q_pop        (q_pop),
    .q_valid      (q_valid),
    .q_sample     (q_sample)
  );

  swst_back #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .clear        (clear),
    .eff_len      (eff_len),
    .q_valid      (q_valid),
    .q_sample     (q_sample),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .fill_count   (fill_count),
    .window_min   (window_min),
    .window_max   (window_max),
    .mean_q8      (mean_q8),
    .stddev_q8    (stddev_q8)
  );

endmodule
